[src/pcb_pkg.sv]
// Shared types and codes for the policy channel buffer.
package pcb_pkg;

   localparam int PAYLOAD_W = 32;
   localparam int SEQ_W     = 32;
   localparam int COUNT_W   = 32;
   localparam int DEPTH_W   = 5;

   localparam logic [1:0] REQ_PUBLISH = 2'd0;
   localparam logic [1:0] REQ_DRAIN   = 2'd1;
   localparam logic [1:0] REQ_EPOCH   = 2'd2;
   localparam logic [1:0] REQ_METRICS = 2'd3;

   localparam logic [2:0] MODE_QUEUE   = 3'd0;
   localparam logic [2:0] MODE_LATEST  = 3'd1;
   localparam logic [2:0] MODE_LATCHED = 3'd2;
   localparam logic [2:0] MODE_PREV    = 3'd3;
   localparam logic [2:0] MODE_BARRIER = 3'd4;

   localparam logic [1:0] POL_DROP_OLDEST = 2'd0;
   localparam logic [1:0] POL_DROP_NEWEST = 2'd1;
   localparam logic [1:0] POL_BLOCK       = 2'd2;
   localparam logic [1:0] POL_FAIL        = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_DROPPED  = 2'd1;
   localparam logic [1:0] ST_BLOCK    = 2'd2;
   localparam logic [1:0] ST_EXCEEDED = 2'd3;

   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_CAPACITY = 2'd1;
   localparam logic [1:0] CSR_POLICY   = 2'd2;

   typedef struct packed {
      logic [1:0]           req_type;
      logic [PAYLOAD_W-1:0] payload_word;
      logic [2:0]           reader_index;
   } pcb_req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic                 item_valid;
      logic [PAYLOAD_W-1:0] message_word;
      logic [SEQ_W-1:0]     message_sequence;
      logic                 last_item;
      logic [DEPTH_W-1:0]   current_depth;
      logic [COUNT_W-1:0]   drops_total;
      logic [COUNT_W-1:0]   published_total;
      logic [COUNT_W-1:0]   delivered_total;
      logic [DEPTH_W-1:0]   peak_depth;
   } pcb_rsp_type;

   typedef struct packed {
      logic accept;
      logic load_item;
   } pcb_cmd_type;

   typedef struct packed {
      logic drain_go;
      logic drain_last;
      logic out_free;
   } pcb_stat_type;

endpackage

[src/policy_channel_buffer.sv]
// Top level of the single-channel message buffer with overflow policy.
// A publish, epoch, metrics or latest-style read request takes one result and
// is accepted again as soon as the result register is free, so such requests
// run at one per cycle while results are taken. A queue drain of n messages
// gives n results, each through a read state and a send state: the FIFO memory has one registered read
// port, and each message is read out before it is loaded into the result
// register. No request is accepted during a drain. Configuration writes are
// always ready and must only be made while the block is idle.
module policy_channel_buffer
   import pcb_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 16,
   parameter int READER_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pcb_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output pcb_rsp_type rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   pcb_cmd_type  cmd;
   pcb_stat_type stat;

   // register writes never wait
   assign csr_ready = 1'b1;

   // controller: request acceptance and drain burst sequencing
   pcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: channel state, FIFO memory, counters, result register
   pcb_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .READER_COUNT (READER_COUNT)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

[src/pcb_ctrl.sv]
// Sequencer for request acceptance and drain bursts.
module pcb_ctrl
   import pcb_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  pcb_stat_type stat,
   output pcb_cmd_type  cmd
);

   typedef enum logic [1:0] {IDLE, READ, SEND} state_type;
   state_type state_ff, state_in;

   always_comb begin
      req_stall     = !(state_ff == IDLE && stat.out_free);
      cmd.accept    = req_valid && !req_stall;
      cmd.load_item = (state_ff == SEND) && stat.out_free;
      state_in      = state_ff;
      unique case (state_ff)
         IDLE: begin
            if (cmd.accept && stat.drain_go) state_in = READ;
         end
         READ: state_in = SEND;
         SEND: begin
            if (stat.out_free) state_in = stat.drain_last ? IDLE : READ;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else state_ff <= state_in;
   end

endmodule

[src/pcb_datapath.sv]
// Channel state, FIFO storage, counters and the result register.
module pcb_datapath
   import pcb_pkg::*;
#(
   parameter int QUEUE_DEPTH  = 16,
   parameter int READER_COUNT = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data,
   input  pcb_req_type  req_data,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output pcb_rsp_type  rsp_data,
   input  pcb_cmd_type  cmd,
   output pcb_stat_type stat
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int RW = (READER_COUNT > 1) ? $clog2(READER_COUNT) : 1;

   function automatic logic [PW-1:0] wrap(input logic [CW:0] s);
      logic [CW:0] r;
      r = s;
      if (r >= (CW+1)'(QUEUE_DEPTH)) r = r - (CW+1)'(QUEUE_DEPTH);
      return PW'(r);
   endfunction

   function automatic logic [RW-1:0] reader_slot(input logic [2:0] v);
      int r;
      r = int'(v);
      for (int i = 0; i < 8; i++) begin
         if (r >= READER_COUNT) r = r - READER_COUNT;
      end
      return RW'(r);
   endfunction

   logic [2:0] mode_ff;
   logic [4:0] cap_ff;
   logic [1:0] pol_ff;

   logic [PAYLOAD_W-1:0] mem_word [QUEUE_DEPTH];
   logic [SEQ_W-1:0]     mem_seq  [QUEUE_DEPTH];
   logic [PAYLOAD_W-1:0] rd_word_ff;
   logic [SEQ_W-1:0]     rd_seq_ff;

   logic [CW-1:0]  count_ff, count_in, stored_ff, stored_in, peak_ff, peak_in;
   logic [PW-1:0]  head_ff, head_in;
   logic [PAYLOAD_W-1:0] nw_ff, nw_in, pw_ff, pw_in;
   logic [SEQ_W-1:0]     ns_ff, ns_in, ps_ff, ps_in, seq_ff, seq_in;
   logic                 np_ff, np_in, pp_ff, pp_in;
   logic [COUNT_W-1:0]   drops_ff, drops_in, pub_ff, pub_in, deliv_ff, deliv_in;
   logic [READER_COUNT-1:0] seen_v_ff;
   logic [SEQ_W-1:0]     seen_s_ff [READER_COUNT];
   logic [PW-1:0]  dptr_ff;
   logic [CW-1:0]  dleft_ff;

   logic          latest, prev_tick, barrier, is_full, ev1, wr_en, seen_set, hit;
   logic [CW-1:0] effcap, c1, c2, extra, view;
   logic [PW-1:0] head1, slot;
   logic [RW-1:0] rsel;
   logic [1:0]    st;
   int            capi;
   pcb_rsp_type   single;

   always_comb begin
      latest    = (mode_ff == MODE_LATEST) || (mode_ff == MODE_LATCHED)
                  || (mode_ff == MODE_PREV);
      prev_tick = (mode_ff == MODE_PREV);
      barrier   = (mode_ff == MODE_BARRIER);
      capi = int'(cap_ff);
      if (capi == 0) capi = 1;
      if (capi > QUEUE_DEPTH) capi = QUEUE_DEPTH;
      effcap  = CW'(capi);
      is_full = count_ff >= effcap;
      rsel    = reader_slot(req_data.reader_index);
      hit     = np_ff && !(seen_v_ff[rsel] && seen_s_ff[rsel] == ns_ff);

      // FIFO insert with eviction of the oldest entries
      ev1   = count_ff >= CW'(QUEUE_DEPTH);
      head1 = ev1 ? wrap((CW+1)'(head_ff) + (CW+1)'(1)) : head_ff;
      slot  = wrap((CW+1)'(head1) + (CW+1)'(count_ff) - (CW+1)'(ev1));
      c1    = ev1 ? count_ff : count_ff + CW'(1);
      c2    = (c1 > effcap) ? effcap : c1;
      extra = c1 - c2;

      count_in = count_ff;  head_in = head_ff;  stored_in = stored_ff;
      nw_in = nw_ff;  ns_in = ns_ff;  np_in = np_ff;
      pw_in = pw_ff;  ps_in = ps_ff;  pp_in = pp_ff;
      seq_in = seq_ff;
      drops_in = drops_ff;  pub_in = pub_ff;  deliv_in = deliv_ff;
      wr_en = 1'b0;  seen_set = 1'b0;  st = ST_OK;
      stat.drain_go = 1'b0;
      single = '0;
      single.last_item = 1'b1;

      case (req_data.req_type)
         REQ_PUBLISH: begin
            seq_in = seq_ff + SEQ_W'(1);
            if (prev_tick) begin
               if (pp_ff) drops_in = drops_ff + COUNT_W'(1);
               pw_in = req_data.payload_word;  ps_in = seq_ff;  pp_in = 1'b1;
               pub_in = pub_ff + COUNT_W'(1);
               stored_in = CW'(np_ff) + CW'(1);
            end else if (!latest && is_full && pol_ff != POL_DROP_OLDEST) begin
               if (pol_ff == POL_DROP_NEWEST) st = ST_DROPPED;
               else if (pol_ff == POL_BLOCK) st = ST_BLOCK;
               else st = ST_EXCEEDED;
               if (pol_ff != POL_BLOCK) drops_in = drops_ff + COUNT_W'(1);
            end else begin
               nw_in = req_data.payload_word;  ns_in = seq_ff;  np_in = 1'b1;
               pub_in = pub_ff + COUNT_W'(1);
               if (latest) begin
                  if (mode_ff == MODE_LATEST && stored_ff != '0)
                     drops_in = drops_ff + COUNT_W'(1);
                  count_in = '0;  head_in = '0;  stored_in = CW'(1);
               end else begin
                  wr_en     = 1'b1;
                  count_in  = c2;
                  stored_in = c2;
                  head_in   = wrap((CW+1)'(head1) + (CW+1)'(extra));
                  drops_in  = drops_ff + COUNT_W'(ev1) + COUNT_W'(extra);
               end
            end
         end
         REQ_EPOCH: begin
            if (prev_tick && pp_ff) begin
               nw_in = pw_ff;  ns_in = ps_ff;  np_in = 1'b1;  pp_in = 1'b0;
               stored_in = CW'(1);
            end
         end
         REQ_DRAIN: begin
            if (latest) begin
               if (hit) begin
                  seen_set = 1'b1;
                  deliv_in = deliv_ff + COUNT_W'(1);
                  single.item_valid       = 1'b1;
                  single.message_word     = nw_ff;
                  single.message_sequence = ns_ff;
               end
            end else if (!((barrier && count_ff < effcap) || count_ff == '0)) begin
               stat.drain_go = 1'b1;
               deliv_in  = deliv_ff + COUNT_W'(count_ff);
               count_in  = '0;  head_in = '0;  stored_in = '0;
            end
         end
         default: ;
      endcase

      peak_in = (stored_in > peak_ff) ? stored_in : peak_ff;
      if (prev_tick) view = CW'(np_in) + CW'(pp_in);
      else if (latest) view = CW'(np_in);
      else view = count_in;

      single.status          = st;
      single.current_depth   = DEPTH_W'(view);
      single.drops_total     = drops_in;
      single.published_total = pub_in;
      single.delivered_total = deliv_in;
      single.peak_depth      = DEPTH_W'(peak_in);

      stat.drain_last = (dleft_ff == CW'(1));
      stat.out_free   = !rsp_valid || !rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (wr_en && cmd.accept) begin
         mem_word[slot] <= req_data.payload_word;
         mem_seq[slot]  <= seq_ff;
      end
      rd_word_ff <= mem_word[dptr_ff];
      rd_seq_ff  <= mem_seq[dptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_QUEUE;  cap_ff <= 5'd1;  pol_ff <= POL_FAIL;
         count_ff <= '0;  head_ff <= '0;  stored_ff <= '0;  peak_ff <= '0;
         nw_ff <= '0;  ns_ff <= '0;  np_ff <= 1'b0;
         pw_ff <= '0;  ps_ff <= '0;  pp_ff <= 1'b0;
         seq_ff <= '0;
         drops_ff <= '0;  pub_ff <= '0;  deliv_ff <= '0;
         seen_v_ff <= '0;
         rsp_valid <= 1'b0;
         dptr_ff <= '0;  dleft_ff <= '0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MODE:     mode_ff <= csr_data[2:0];
               CSR_CAPACITY: cap_ff  <= csr_data[4:0];
               CSR_POLICY:   pol_ff  <= csr_data[1:0];
               default: ;
            endcase
         end
         if (cmd.accept) begin
            count_ff <= count_in;  head_ff <= head_in;  stored_ff <= stored_in;
            peak_ff <= peak_in;
            nw_ff <= nw_in;  ns_ff <= ns_in;  np_ff <= np_in;
            pw_ff <= pw_in;  ps_ff <= ps_in;  pp_ff <= pp_in;
            seq_ff <= seq_in;
            drops_ff <= drops_in;  pub_ff <= pub_in;  deliv_ff <= deliv_in;
            if (seen_set) seen_v_ff[rsel] <= 1'b1;
            if (stat.drain_go) begin
               dptr_ff  <= head_ff;
               dleft_ff <= count_ff;
            end
         end else if (cmd.load_item) begin
            dptr_ff  <= wrap((CW+1)'(dptr_ff) + (CW+1)'(1));
            dleft_ff <= dleft_ff - CW'(1);
         end
         if ((cmd.accept && !stat.drain_go) || cmd.load_item) rsp_valid <= 1'b1;
         else if (!rsp_stall) rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && seen_set) seen_s_ff[rsel] <= ns_ff;
      if (cmd.accept && !stat.drain_go) begin
         rsp_data <= single;
      end else if (cmd.load_item) begin
         rsp_data.status           <= ST_OK;
         rsp_data.item_valid       <= 1'b1;
         rsp_data.message_word     <= rd_word_ff;
         rsp_data.message_sequence <= rd_seq_ff;
         rsp_data.last_item        <= stat.drain_last;
         rsp_data.current_depth    <= DEPTH_W'(count_ff);
         rsp_data.drops_total      <= drops_ff;
         rsp_data.published_total  <= pub_ff;
         rsp_data.delivered_total  <= deliv_ff;
         rsp_data.peak_depth       <= DEPTH_W'(peak_ff);
      end
   end

endmodule

[bench/tb_top.sv]
// Self-checking bench for policy_channel_buffer: scoreboard predictor, random traffic.
module tb_top;
   import pcb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   // Scoreboard: a copy of the channel state that predicts every response.
   class channel_scoreboard;
      logic [2:0]  mode;
      logic [4:0]  capacity;
      logic [1:0]  policy;
      logic [31:0] fifo_word [16];
      logic [31:0] fifo_seq [16];
      int unsigned fifo_cnt, fifo_hd;
      logic [31:0] newest_w, newest_s, pend_w, pend_s, next_seq;
      bit          newest_ok, pend_ok;
      bit          seen_ok [8];
      logic [31:0] seen_seq [8];
      int unsigned held;
      logic [31:0] drops, pubs, delivered;
      int unsigned peak;
      pcb_rsp_type awaited [$];
      int          errors;
      int          checked;

      function new();
         mode = MODE_QUEUE; capacity = 1; policy = POL_FAIL;
         fifo_cnt = 0; fifo_hd = 0; newest_ok = 0; pend_ok = 0;
         newest_w = 0; newest_s = 0; pend_w = 0; pend_s = 0; next_seq = 0;
         foreach (seen_ok[i]) seen_ok[i] = 0;
         held = 0; drops = 0; pubs = 0; delivered = 0; peak = 0;
         errors = 0; checked = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            CSR_MODE:     mode = val[2:0];
            CSR_CAPACITY: capacity = val[4:0];
            CSR_POLICY:   policy = val[1:0];
            default: ;
         endcase
      endfunction

      function bit latest_kind();
         return mode == MODE_LATEST || mode == MODE_LATCHED || mode == MODE_PREV;
      endfunction

      function int unsigned cap_eff();
         if (capacity == 0) return 1;
         if (capacity > 16) return 16;
         return capacity;
      endfunction

      function void bump_peak();
         if (held > peak) peak = held;
      endfunction

      function void push(logic [1:0] st, bit vld, logic [31:0] w, logic [31:0] s, bit last);
         pcb_rsp_type r;
         r.status = st;
         r.item_valid = vld;
         r.message_word = vld ? w : '0;
         r.message_sequence = vld ? s : '0;
         r.last_item = last;
         if (mode == MODE_PREV) r.current_depth = 5'(int'(newest_ok) + int'(pend_ok));
         else if (latest_kind()) r.current_depth = 5'(newest_ok);
         else r.current_depth = 5'(fifo_cnt);
         r.drops_total = drops;
         r.published_total = pubs;
         r.delivered_total = delivered;
         r.peak_depth = 5'(peak);
         awaited = {awaited, r};
      endfunction

      function logic [1:0] publish(logic [31:0] w);
         logic [31:0] s;
         int unsigned slot;
         s = next_seq;
         next_seq++;
         if (mode == MODE_PREV) begin
            if (pend_ok) drops++;
            pend_w = w; pend_s = s; pend_ok = 1;
            pubs++;
            held = int'(newest_ok) + 1;
            bump_peak();
            return ST_OK;
         end
         if (!latest_kind() && fifo_cnt >= cap_eff()) begin
            if (policy == POL_DROP_NEWEST) begin
               drops++;
               return ST_DROPPED;
            end
            if (policy == POL_BLOCK) return ST_BLOCK;
            if (policy == POL_FAIL) begin
               drops++;
               return ST_EXCEEDED;
            end
         end
         newest_w = w; newest_s = s; newest_ok = 1;
         if (latest_kind()) begin
            if (mode == MODE_LATEST && held > 0) drops++;
            fifo_cnt = 0; fifo_hd = 0; held = 1;
         end else begin
            if (fifo_cnt >= 16) begin
               fifo_hd = (fifo_hd + 1) % 16; fifo_cnt--; drops++;
            end
            slot = (fifo_hd + fifo_cnt) % 16;
            fifo_word[slot] = w; fifo_seq[slot] = s; fifo_cnt++;
            while (fifo_cnt > cap_eff()) begin
               fifo_hd = (fifo_hd + 1) % 16; fifo_cnt--; drops++;
            end
            held = fifo_cnt;
         end
         pubs++;
         bump_peak();
         return ST_OK;
      endfunction

      // Note an accepted request and queue the responses it should cause.
      function void note_request(pcb_req_type q);
         int unsigned rd, n, hd, slot;
         logic [1:0] st;
         rd = q.reader_index;
         case (q.req_type)
            REQ_PUBLISH: begin
               st = publish(q.payload_word);
               push(st, 0, 0, 0, 1);
            end
            REQ_EPOCH: begin
               if (mode == MODE_PREV && pend_ok) begin
                  newest_w = pend_w; newest_s = pend_s; newest_ok = 1;
                  pend_ok = 0; held = 1;
                  bump_peak();
               end
               push(ST_OK, 0, 0, 0, 1);
            end
            REQ_METRICS: push(ST_OK, 0, 0, 0, 1);
            default: begin
               if (latest_kind()) begin
                  if (newest_ok && !(seen_ok[rd] && seen_seq[rd] == newest_s)) begin
                     seen_ok[rd] = 1; seen_seq[rd] = newest_s;
                     delivered++;
                     push(ST_OK, 1, newest_w, newest_s, 1);
                  end else push(ST_OK, 0, 0, 0, 1);
               end else if ((mode == MODE_BARRIER && fifo_cnt < cap_eff()) || fifo_cnt == 0)
                  push(ST_OK, 0, 0, 0, 1);
               else begin
                  n = fifo_cnt; hd = fifo_hd;
                  delivered += n;
                  fifo_cnt = 0; fifo_hd = 0; held = 0;
                  for (int k = 0; k < n; k++) begin
                     slot = (hd + k) % 16;
                     push(ST_OK, 1, fifo_word[slot], fifo_seq[slot], k + 1 == n);
                  end
               end
            end
         endcase
      endfunction

      // Compare one accepted response with the oldest expectation.
      function void check_response(pcb_rsp_type got);
         pcb_rsp_type want;
         checked++;
         if (awaited.size() == 0) begin
            $error("unexpected response %p", got);
            errors++;
            return;
         end
         want = awaited[0];
         awaited.delete(0);
         if (got.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, got.status); errors++;
         end
         if (got.item_valid !== want.item_valid) begin
            $error("item_valid exp %0d got %0d", want.item_valid, got.item_valid); errors++;
         end
         if (got.message_word !== want.message_word) begin
            $error("message_word exp %h got %h", want.message_word, got.message_word);
            errors++;
         end
         if (got.message_sequence !== want.message_sequence) begin
            $error("message_sequence exp %0d got %0d", want.message_sequence,
                   got.message_sequence);
            errors++;
         end
         if (got.last_item !== want.last_item) begin
            $error("last_item exp %0d got %0d", want.last_item, got.last_item); errors++;
         end
         if (got.current_depth !== want.current_depth) begin
            $error("current_depth exp %0d got %0d", want.current_depth, got.current_depth);
            errors++;
         end
         if (got.drops_total !== want.drops_total) begin
            $error("drops_total exp %0d got %0d", want.drops_total, got.drops_total);
            errors++;
         end
         if (got.published_total !== want.published_total) begin
            $error("published_total exp %0d got %0d", want.published_total,
                   got.published_total);
            errors++;
         end
         if (got.delivered_total !== want.delivered_total) begin
            $error("delivered_total exp %0d got %0d", want.delivered_total,
                   got.delivered_total);
            errors++;
         end
         if (got.peak_depth !== want.peak_depth) begin
            $error("peak_depth exp %0d got %0d", want.peak_depth, got.peak_depth); errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   pcb_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   pcb_rsp_type rsp_data;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_MODE;
   logic [31:0] csr_data = '0;

   channel_scoreboard board = new();
   int          stall_mode;   // receiver back-pressure pattern, changed per phase
   int          stall_phase = 0;
   int          req_count = 0;
   logic [31:0] or_seen = '0, and_seen = '1;

   policy_channel_buffer dut (.*);

   always #6 clock = ~clock;

   // Receiver: sample at the rising edge, choose the next stall at the falling edge.
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);

   always @(negedge clock) begin
      stall_phase++;
      case (stall_mode)
         0: rsp_stall <= 0;                           // never stalls
         1: rsp_stall <= ($urandom_range(0, 3) == 0);  // light random
         2: rsp_stall <= (stall_phase % 5) < 3;       // heavy periodic
         default: rsp_stall <= ($urandom_range(0, 9) == 0) ? 1 : 0;
      endcase
   end

   // Hold the request until the block takes it; leaves valid high for back-to-back.
   task automatic send_request(logic [1:0] kind, logic [31:0] word, logic [2:0] rdr);
      req_valid <= 1;
      req_data <= '{req_type: kind, payload_word: word, reader_index: rdr};
      do @(posedge clock); while (req_stall);
      board.note_request(req_data);
      req_count++;
      or_seen |= req_data.payload_word;
      and_seen &= req_data.payload_word;
      @(negedge clock);
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 0;
      repeat (cycles) @(negedge clock);
   endtask

   // Wait for every expected response, then a little longer for a drain to settle.
   task automatic wait_quiet();
      req_valid <= 0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Valid stays high across consecutive writes; the caller drops it.
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, val);
      @(negedge clock);
   endtask

   task automatic set_channel(logic [2:0] md, logic [4:0] cap, logic [1:0] pol);
      wait_quiet();
      write_csr(CSR_MODE, md);
      write_csr(CSR_CAPACITY, cap);
      write_csr(CSR_POLICY, pol);
      csr_valid <= 0;
   endtask

   // One random burst: publishes dominate, drains and epochs follow.
   task automatic random_burst();
      int len, pick;
      logic [1:0] kind;
      logic [31:0] word;
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) kind = REQ_PUBLISH;
         else if (pick < 80) kind = REQ_DRAIN;
         else if (pick < 92) kind = REQ_EPOCH;
         else kind = REQ_METRICS;
         word = $urandom();
         if ($urandom_range(0, 9) == 0) word = ($urandom_range(0, 1) != 0) ? '1 : '0;
         send_request(kind, word, 3'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
   endtask

   initial begin
      int phase_reqs;
      stall_mode = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: fail-fast on capacity one, then drain, extremes of payload.
      send_request(REQ_PUBLISH, 32'h0000_0000, 3'd0);
      send_request(REQ_PUBLISH, 32'hFFFF_FFFF, 3'd7);
      send_request(REQ_METRICS, 32'h0, 3'd0);
      send_request(REQ_DRAIN, 32'h0, 3'd0);
      send_request(REQ_DRAIN, 32'h0, 3'd0);         // empty drain
      send_request(REQ_EPOCH, 32'h0, 3'd0);         // epoch outside previous-tick
      set_channel(MODE_QUEUE, 5'd16, POL_DROP_NEWEST);
      for (int i = 0; i < 17; i++) send_request(REQ_PUBLISH, 32'hA5A5_0000 + i, 3'd0);
      send_request(REQ_DRAIN, 32'h0, 3'd0);
      set_channel(MODE_QUEUE, 5'd3, POL_BLOCK);
      for (int i = 0; i < 4; i++) send_request(REQ_PUBLISH, 32'h5A5A_0000 + i, 3'd0);
      // capacity lowered under a full FIFO, then drop-oldest trims it
      set_channel(MODE_QUEUE, 5'd1, POL_DROP_OLDEST);
      send_request(REQ_PUBLISH, 32'h1234_5678, 3'd0);
      send_request(REQ_DRAIN, 32'h0, 3'd0);
      set_channel(3'd7, 5'd0, POL_DROP_OLDEST);     // unused mode, capacity zero
      send_request(REQ_PUBLISH, 32'h1, 3'd0);
      send_request(REQ_PUBLISH, 32'h2, 3'd0);
      send_request(REQ_DRAIN, 32'h0, 3'd0);
      set_channel(MODE_BARRIER, 5'd31, POL_DROP_OLDEST);   // capacity above depth
      send_request(REQ_DRAIN, 32'h0, 3'd0);
      wait_quiet();                                 // sender holds until all came back

      // Random phases across every mode with random policies; receiver pattern varies.
      for (int ph = 0; ph < 14; ph++) begin
         logic [2:0] md;
         md = (ph < 10) ? 3'(ph % 5) : 3'($urandom_range(0, 7));
         set_channel(md, 5'((ph % 4 == 0) ? 1 : (ph % 4 == 1) ? 16 : $urandom_range(0, 20)),
                     2'($urandom_range(0, 3)));
         stall_mode = ph % 4;
         phase_reqs = req_count;
         while (req_count - phase_reqs < 8) random_burst();
         if (md == MODE_BARRIER || md == MODE_QUEUE) send_request(REQ_DRAIN, 32'h0, 3'd0);
      end
      wait_quiet();
      stall_mode = 0;
      repeat (20) @(negedge clock);
      $display("Checked %0d responses from %0d requests over five modes, all policies,",
               board.checked, req_count);
      $display("capacities 0 to 20 and varied back-pressure (payload bits: or %h and %h).",
               or_seen, and_seen);
      if (board.errors == 0 && board.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("Verification failed");
      $finish;
   end
endmodule
